@@ rtl/size_class_map_engine_macros.svh @@
// Assertion macros for the size class map engine.
`ifndef SIZE_CLASS_MAP_ENGINE_MACROS_SVH
`define SIZE_CLASS_MAP_ENGINE_MACROS_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define SCM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that an antecedent implies a consequent in the next cycle.
`define SCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/scme_pkg.sv @@
// Shared types, constants and helpers of the size class map engine.
package scme_pkg;

    localparam int MAX_OBJECT_SIZE = 262144;
    localparam int SMALL_LIMIT     = 1024;
    localparam int MIN_ALIGNMENT   = 8;
    localparam int CLASS_COUNT     = 128;
    localparam int INDEX_DEPTH     = 4096;
    localparam int CLS_W           = $clog2(CLASS_COUNT);
    localparam int IDX_W           = $clog2(INDEX_DEPTH);
    localparam int SIZE_W          = 19;
    localparam int REQ_W           = 20;
    localparam int PAGE_W          = 8;
    localparam int SPAN_W          = 40;
    localparam int BIG_ADD         = 127 + (120 << 7);

    localparam logic [2:0] REG_PAGE_SHIFT  = 3'd0;
    localparam logic [2:0] REG_MOVE_BUDGET = 3'd1;
    localparam logic [2:0] REG_MOVE_MIN    = 3'd2;
    localparam logic [2:0] REG_MOVE_MAX    = 3'd3;
    localparam logic [2:0] REG_WASTE_SHIFT = 3'd4;

    typedef struct packed {
        logic [4:0]  page_shift;
        logic [20:0] move_budget;
        logic [6:0]  move_min;
        logic [6:0]  move_max;
        logic [2:0]  waste_shift;
    } cfg_t;

    typedef struct packed {
        logic             too_large;
        logic [IDX_W-1:0] idx;
    } lookup_t;

    // Size index of a request size; wide enough for any size up to 2^20.
    function automatic logic [13:0] index_of(input logic [REQ_W-1:0] s);
        logic [REQ_W:0] t;
        begin
            if (s > REQ_W'(SMALL_LIMIT))
                t = ({1'b0, s} + (REQ_W+1)'(BIG_ADD)) >> 7;
            else
                t = ({1'b0, s} + (REQ_W+1)'(7)) >> 3;
            index_of = t[13:0];
        end
    endfunction

endpackage

@@ rtl/scme_builder.sv @@
// Table builder: walks candidate sizes and writes class and index tables.
module scme_builder
    import scme_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  cfg_t              cfg,
    output logic              busy,
    output logic              cls_we,
    output logic [CLS_W-1:0]  cls_addr,
    output logic [SIZE_W-1:0] cls_size,
    output logic [PAGE_W-1:0] cls_pages,
    output logic              idx_we,
    output logic [IDX_W-1:0]  idx_addr,
    output logic [CLS_W-1:0]  idx_data
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CLEAR  = 4'd1;
    localparam logic [3:0] ST_CAND   = 4'd2;
    localparam logic [3:0] ST_DIV    = 4'd3;
    localparam logic [3:0] ST_SPAN   = 4'd4;
    localparam logic [3:0] ST_MOD    = 4'd5;
    localparam logic [3:0] ST_CHECK  = 4'd6;
    localparam logic [3:0] ST_MERGE  = 4'd7;
    localparam logic [3:0] ST_COMMIT = 4'd8;
    localparam logic [3:0] ST_FILL   = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [IDX_W:0] clr_reg, clr_next;
    logic [4:0] ps;
    logic [SPAN_W-1:0] page;

    logic [REQ_W-1:0]  size_reg, size_next;
    logic [SPAN_W-1:0] span_reg, span_next;
    logic [6:0]  blocks_reg, blocks_next;
    logic [SPAN_W-1:0] pages_prev_reg, pages_prev_next;
    logic [CLS_W:0] sc_reg, sc_next;
    logic [SIZE_W-1:0] prev_size_reg;

    // shared serial divider: quotient and remainder of num / den
    logic [SPAN_W-1:0] num_reg, num_next, q_reg, q_next, r_reg, r_next;
    logic [SPAN_W-1:0] den_reg, den_next;
    logic [5:0] dcnt_reg, dcnt_next;
    logic [1:0] dsel_reg, dsel_next;
    logic [SPAN_W-1:0] cnt_reg, cnt_next;

    // class table shadow for merge and fill
    logic [SIZE_W-1:0] csize_mem [CLASS_COUNT];
    logic [CLS_W-1:0]  fcls_reg, fcls_next;
    logic [REQ_W:0]    fs_reg, fs_next;
    logic [SIZE_W-1:0] ftop_reg;
    logic [CLS_W-1:0]  rd_addr;

    logic [REQ_W-1:0] step;
    logic [4:0] lg;
    logic [SPAN_W:0] r_shift;
    logic [13:0] fidx;
    logic [SPAN_W-1:0] pages_now;
    logic [6:0] batch;
    logic [20:0] bq;

    always_comb
    begin
        ps = cfg.page_shift;
        if (ps < 5'd12) ps = 5'd12;
        if (ps > 5'd16) ps = 5'd16;
        page = SPAN_W'(1) << ps;
    end

    always_comb
    begin
        lg = 5'd0;
        for (int i = 0; i < REQ_W; i++)
            if (size_reg[i]) lg = 5'(i);
        if (size_reg > REQ_W'(MAX_OBJECT_SIZE))
            step = page[REQ_W-1:0];
        else if (size_reg >= REQ_W'(128))
            step = (REQ_W'(1) << lg) >> 3;
        else if (size_reg >= REQ_W'(16))
            step = REQ_W'(16);
        else
            step = REQ_W'(8);
        if (SPAN_W'(step) > page) step = page[REQ_W-1:0];
        if (step == '0) step = REQ_W'(8);
    end

    assign r_shift   = {r_reg, num_reg[SPAN_W-1]};
    assign pages_now = span_reg >> ps;
    assign bq        = q_reg[20:0];
    assign fidx      = index_of(fs_reg[REQ_W-1:0]);
    assign rd_addr   = (state_reg == ST_FILL) ? fcls_next : CLS_W'(sc_reg - 1'b1);

    always_comb
    begin
        if (bq < 21'(cfg.move_min)) batch = cfg.move_min;
        else batch = bq[6:0];
        if (bq >= 21'(cfg.move_min) && bq > 21'(cfg.move_max)) batch = cfg.move_max;
        else if (batch > cfg.move_max) batch = cfg.move_max;
    end

    always_ff @(posedge clk)
    begin
        if (cls_we)
            csize_mem[cls_addr] <= cls_size;
        prev_size_reg <= csize_mem[rd_addr];
        ftop_reg      <= csize_mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        size_next = size_reg;
        span_next = span_reg;
        blocks_next = blocks_reg;
        pages_prev_next = pages_prev_reg;
        sc_next = sc_reg;
        num_next = num_reg;
        q_next = q_reg;
        r_next = r_reg;
        den_next = den_reg;
        dcnt_next = dcnt_reg;
        dsel_next = dsel_reg;
        cnt_next = cnt_reg;
        fcls_next = fcls_reg;
        fs_next = fs_reg;
        cls_we = 1'b0;
        cls_addr = '0;
        cls_size = '0;
        cls_pages = '0;
        idx_we = 1'b0;
        idx_addr = '0;
        idx_data = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_CLEAR:
            begin
                idx_we = 1'b1;
                idx_addr = clr_reg[IDX_W-1:0];
                cls_we = (clr_reg < (IDX_W+1)'(CLASS_COUNT));
                cls_addr = clr_reg[CLS_W-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (IDX_W+1)'(INDEX_DEPTH - 1))
                begin
                    state_next = ST_CAND;
                    size_next = REQ_W'(MIN_ALIGNMENT);
                    sc_next = (CLS_W+1)'(1);
                    pages_prev_next = '0;
                    dsel_next = 2'd0;
                    num_next = SPAN_W'(cfg.move_budget);
                    den_next = SPAN_W'(REQ_W'(MIN_ALIGNMENT));
                    q_next = '0;
                    r_next = '0;
                    dcnt_next = '0;
                end
            end
            ST_CAND, ST_DIV:
            begin
                // one restoring divide step per cycle
                if (r_shift >= {1'b0, den_reg})
                begin
                    r_next = r_shift[SPAN_W-1:0] - den_reg;
                    q_next = {q_reg[SPAN_W-2:0], 1'b1};
                end
                else
                begin
                    r_next = r_shift[SPAN_W-1:0];
                    q_next = {q_reg[SPAN_W-2:0], 1'b0};
                end
                num_next = num_reg << 1;
                dcnt_next = dcnt_reg + 1'b1;
                state_next = ST_DIV;
                if (dcnt_reg == 6'(SPAN_W))
                begin
                    q_next = q_reg;
                    r_next = r_reg;
                    num_next = num_reg;
                    unique case (dsel_reg)
                        2'd0:
                        begin
                            blocks_next = {2'b00, batch[6:2]};
                            span_next = page;
                            state_next = ST_SPAN;
                        end
                        2'd1:
                        begin
                            state_next = ST_MOD;
                        end
                        default:
                        begin
                            state_next = ST_MERGE;
                        end
                    endcase
                end
            end
            ST_SPAN:
            begin
                dsel_next = 2'd1;
                num_next = span_reg;
                den_next = SPAN_W'(size_reg);
                q_next = '0;
                r_next = '0;
                dcnt_next = '0;
                state_next = ST_DIV;
            end
            ST_MOD:
            begin
                if (r_reg > (span_reg >> cfg.waste_shift))
                begin
                    span_next = span_reg + page;
                    state_next = ST_SPAN;
                end
                else if (q_reg < SPAN_W'(blocks_reg))
                begin
                    span_next = span_reg + page;
                    state_next = ST_SPAN;
                end
                else
                begin
                    cnt_next = q_reg;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sc_reg > (CLS_W+1)'(1) && pages_now == pages_prev_reg
                    && prev_size_reg != '0)
                begin
                    dsel_next = 2'd2;
                    num_next = span_reg;
                    den_next = SPAN_W'(prev_size_reg);
                    q_next = '0;
                    r_next = '0;
                    dcnt_next = '0;
                    state_next = ST_DIV;
                end
                else
                    state_next = ST_COMMIT;
            end
            ST_MERGE:
            begin
                if (q_reg == cnt_reg)
                begin
                    // keep the page count of the class that absorbs this size
                    cls_we = 1'b1;
                    cls_addr = CLS_W'(sc_reg - 1'b1);
                    cls_size = size_reg[SIZE_W-1:0];
                    cls_pages = (pages_now > SPAN_W'(255)) ? 8'd255 : pages_now[7:0];
                    state_next = ST_COMMIT;
                    dsel_next = 2'd3;
                end
                else
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (dsel_reg != 2'd3)
                begin
                    cls_we = 1'b1;
                    cls_size = size_reg[SIZE_W-1:0];
                    cls_pages = (pages_now > SPAN_W'(255)) ? 8'd255 : pages_now[7:0];
                    pages_prev_next = pages_now;
                    if (sc_reg >= (CLS_W+1)'(CLASS_COUNT))
                        cls_addr = CLS_W'(CLASS_COUNT - 1);
                    else
                    begin
                        cls_addr = sc_reg[CLS_W-1:0];
                        sc_next = sc_reg + 1'b1;
                    end
                end
                size_next = size_reg + step;
                if (size_reg + step > REQ_W'(MAX_OBJECT_SIZE))
                begin
                    state_next = ST_FILL;
                    fcls_next = CLS_W'(1);
                    fs_next = '0;
                end
                else
                begin
                    dsel_next = 2'd0;
                    num_next = SPAN_W'(cfg.move_budget);
                    den_next = SPAN_W'(size_reg + step);
                    q_next = '0;
                    r_next = '0;
                    dcnt_next = '0;
                    state_next = ST_DIV;
                end
            end
            ST_FILL:
            begin
                // write one index entry per cycle for class fcls, except when moving to the next class
                if ((CLS_W+1)'(fcls_reg) >= sc_reg)
                    state_next = ST_IDLE;
                else if (fs_reg > (REQ_W+1)'(ftop_reg))
                begin
                    fcls_next = fcls_reg + 1'b1;
                    fs_next = (REQ_W+1)'(ftop_reg) + (REQ_W+1)'(MIN_ALIGNMENT);
                    if ((CLS_W+1)'(fcls_next) >= sc_reg || fcls_reg == CLS_W'(CLASS_COUNT - 1))
                        state_next = ST_IDLE;
                end
                else
                begin
                    if (fidx < 14'(INDEX_DEPTH))
                    begin
                        idx_we = 1'b1;
                        idx_addr = fidx[IDX_W-1:0];
                        idx_data = fcls_reg;
                    end
                    fs_next = fs_reg + (REQ_W+1)'(MIN_ALIGNMENT);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (start)
        begin
            state_next = ST_CLEAR;
            clr_next = '0;
        end
    end

    // ftop follows the class being filled: reread when the class advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            sc_reg <= '0;
            dsel_reg <= '0;
            dcnt_reg <= '0;
            fcls_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            sc_reg <= sc_next;
            dsel_reg <= dsel_next;
            dcnt_reg <= dcnt_next;
            fcls_reg <= fcls_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg <= size_next;
        span_reg <= span_next;
        blocks_reg <= blocks_next;
        pages_prev_reg <= pages_prev_next;
        num_reg <= num_next;
        q_reg <= q_next;
        r_reg <= r_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        fs_reg <= fs_next;
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ rtl/scme_front.sv @@
// Front end: accepts requests and computes the size index.
module scme_front
    import scme_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [REQ_W-1:0] req,
    output logic             q_valid,
    input  logic             q_ready,
    output lookup_t          q_data
);

    logic    valid_reg;
    lookup_t data_reg;
    logic [13:0] idx;

    assign idx      = index_of(req);
    assign in_ready = !valid_reg || q_ready;
    assign q_valid  = valid_reg;
    assign q_data   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg.too_large <= (req > REQ_W'(MAX_OBJECT_SIZE));
            data_reg.idx <= (idx >= 14'(INDEX_DEPTH)) ? IDX_W'(INDEX_DEPTH - 1)
                                                      : idx[IDX_W-1:0];
        end
    end

endmodule

@@ rtl/scme_back.sv @@
// Back end: reads the tables and drives the result stream.
module scme_back
    import scme_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  lookup_t           q_data,
    input  logic              cls_we,
    input  logic [CLS_W-1:0]  cls_addr,
    input  logic [SIZE_W-1:0] cls_size,
    input  logic [PAGE_W-1:0] cls_pages,
    input  logic              idx_we,
    input  logic [IDX_W-1:0]  idx_addr,
    input  logic [CLS_W-1:0]  idx_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CLS_W-1:0]  class_number,
    output logic [SIZE_W-1:0] class_bytes,
    output logic [PAGE_W-1:0] span_pages,
    output logic              too_large
);

    logic [CLS_W-1:0]  idx_mem  [INDEX_DEPTH];
    logic [SIZE_W-1:0] size_mem [CLASS_COUNT];
    logic [PAGE_W-1:0] page_mem [CLASS_COUNT];

    // stage 1: index read, stage 2: class read
    logic s1_valid_reg, s2_valid_reg;
    logic s1_big_reg, s2_big_reg;
    logic [CLS_W-1:0] s1_cls_reg, s2_cls_reg;
    logic [SIZE_W-1:0] s2_size_reg;
    logic [PAGE_W-1:0] s2_pages_reg;
    logic adv2, adv1;

    assign adv2    = !s2_valid_reg || out_ready;
    assign adv1    = !s1_valid_reg || adv2;
    assign q_ready = adv1;

    always_ff @(posedge clk)
    begin
        if (idx_we)
            idx_mem[idx_addr] <= idx_data;
        if (cls_we)
        begin
            size_mem[cls_addr] <= cls_size;
            page_mem[cls_addr] <= cls_pages;
        end
        if (adv1)
        begin
            s1_cls_reg <= idx_mem[q_data.idx];
            s1_big_reg <= q_data.too_large;
        end
        if (adv2)
        begin
            s2_size_reg  <= size_mem[s1_cls_reg];
            s2_pages_reg <= page_mem[s1_cls_reg];
            s2_cls_reg   <= s1_cls_reg;
            s2_big_reg   <= s1_big_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1) s1_valid_reg <= q_valid;
            if (adv2) s2_valid_reg <= s1_valid_reg;
        end
    end

    assign out_valid    = s2_valid_reg;
    assign too_large    = s2_big_reg;
    assign class_number = s2_big_reg ? '0 : s2_cls_reg;
    assign class_bytes  = (s2_big_reg || s2_cls_reg == '0) ? '0 : s2_size_reg;
    assign span_pages   = (s2_big_reg || s2_cls_reg == '0) ? '0 : s2_pages_reg;

endmodule

@@ rtl/size_class_map_engine.sv @@
// Top level of the size class map engine.
//  channel | direction | handshake          | payload
//  s_axis  | in        | tvalid/tready      | request_size
//  m_axis  | out       | tvalid/tready      | class_number, class_bytes, span_pages, too_large
//  cfg     | in        | cfg_we             | cfg_index, cfg_data
// One request per cycle unless busy or stalled; results pass the front, s1 and s2 registers.
// After reset and after each write to a defined register the tables are rebuilt: a
// clearing pass over all 4096 index entries, then a candidate walk with a serial 40-step
// divider per divide, then the index fill; no request is taken meanwhile.
// Either side may stall; the front register and back pipeline hold their items.
`include "size_class_map_engine_macros.svh"
module size_class_map_engine
    import scme_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [19:0] request_size
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [6:0] class_number, [25:7] class_bytes,
                                        // [33:26] span_pages, [34] too_large
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [20:0] cfg_data
);

    cfg_t cfg_reg;
    logic start_reg;
    logic busy;
    logic front_ready;
    logic q_valid, q_ready;
    lookup_t q_data;
    logic cls_we, idx_we;
    logic [CLS_W-1:0] cls_addr, idx_data, class_number;
    logic [SIZE_W-1:0] cls_size, class_bytes;
    logic [PAGE_W-1:0] cls_pages, span_pages;
    logic [IDX_W-1:0] idx_addr;
    logic too_large;
    logic hit;

    assign hit = cfg_we && (cfg_index == REG_PAGE_SHIFT || cfg_index == REG_MOVE_BUDGET
              || cfg_index == REG_MOVE_MIN || cfg_index == REG_MOVE_MAX
              || cfg_index == REG_WASTE_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.page_shift  <= 5'd13;
            cfg_reg.move_budget <= 21'd65536;
            cfg_reg.move_min    <= 7'd2;
            cfg_reg.move_max    <= 7'd32;
            cfg_reg.waste_shift <= 3'd3;
            start_reg <= 1'b0;
        end
        else
        begin
            start_reg <= hit;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_PAGE_SHIFT:  cfg_reg.page_shift  <= cfg_data[4:0];
                    REG_MOVE_BUDGET: cfg_reg.move_budget <= cfg_data;
                    REG_MOVE_MIN:    cfg_reg.move_min    <= cfg_data[6:0];
                    REG_MOVE_MAX:    cfg_reg.move_max    <= cfg_data[6:0];
                    REG_WASTE_SHIFT: cfg_reg.waste_shift <= cfg_data[2:0];
                    default: ;
                endcase
            end
        end
    end

    scme_builder u_builder (
        .clk(clk), .rst_n(rst_n), .start(start_reg), .cfg(cfg_reg), .busy(busy),
        .cls_we(cls_we), .cls_addr(cls_addr), .cls_size(cls_size), .cls_pages(cls_pages),
        .idx_we(idx_we), .idx_addr(idx_addr), .idx_data(idx_data)
    );

    scme_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid && !busy && !start_reg),
        .in_ready(front_ready), .req(s_axis_tdata[REQ_W-1:0]),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    assign s_axis_tready = front_ready && !busy && !start_reg;

    scme_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .cls_we(cls_we), .cls_addr(cls_addr), .cls_size(cls_size), .cls_pages(cls_pages),
        .idx_we(idx_we), .idx_addr(idx_addr), .idx_data(idx_data),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .class_number(class_number), .class_bytes(class_bytes),
        .span_pages(span_pages), .too_large(too_large)
    );

    assign m_axis_tdata = {5'b0, too_large, span_pages, class_bytes, class_number};

    `SCM_ASSERT_IMP(a_no_accept_busy, clk, rst_n, busy, !s_axis_tready)
    `SCM_ASSERT_IMP(a_big_zero, clk, rst_n, m_axis_tvalid && too_large,
        class_number == '0 && class_bytes == '0)
    `SCM_ASSERT_NEXT(a_cfg_rebuild, clk, rst_n, hit, busy || start_reg)

endmodule
